// ===== src/bpa_pkg.sv =====
// Shared constants, types and helpers for the buddy page allocator.
`default_nettype none

package bpa_pkg;

   // Segment geometry
   localparam int MAX_PAGES  = 4096;
   localparam int NUM_ORDERS = 13;
   localparam int PAGE_W     = $clog2(MAX_PAGES);
   // Page numbers, links and sums that may reach or pass the end of the segment
   localparam int PG_W       = PAGE_W + 1;
   localparam int ORD_W      = 4;
   localparam logic [PG_W-1:0] NIL = PG_W'(MAX_PAGES);

   typedef enum logic [1:0] {
      CMD_INIT    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_FREE    = 2'd2,
      CMD_RESERVE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK           = 3'd0,
      STS_NO_BLOCK     = 3'd1,
      STS_RESERVED     = 3'd2,
      STS_ALREADY_FREE = 3'd3,
      STS_OUT_OF_RANGE = 3'd4,
      STS_BAD_RANGE    = 3'd5
   } status_type;

   // Per-page order and flags
   typedef struct packed {
      logic [ORD_W-1:0] ord;
      logic             rsv;
      logic             alloc;
      logic             head;
   } meta_type;

   typedef struct packed {
      logic ord;
      logic rsv;
      logic alloc;
      logic head;
   } meta_we_type;

   // Per-page free-list links
   typedef struct packed {
      logic [PG_W-1:0] nxt;
      logic [PG_W-1:0] prv;
   } link_type;

   typedef struct packed {
      logic nxt;
      logic prv;
   } link_we_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_IN_START, S_IN_BLK, S_IN_PG, S_IN_NEXT,
      S_AL_START, S_AL_LOOP, S_AL_SPLIT, S_AL_MARK,
      S_FR_START, S_FR_CHECK, S_FR_MERGE, S_FR_BUDDY, S_FR_JOIN, S_FR_ORD,
      S_FR_PUSH, S_FR_MARK,
      S_RS_START, S_RS_HEAD, S_RS_PAGE, S_RS_RD, S_RS_NEXT, S_RS_FILL, S_RS_SPLIT,
      S_SP_RD, S_SP_CHK, S_SP_ORD, S_SP_BUD, S_SP_PUSHB, S_SP_END,
      S_DR_RD, S_DR_PREV, S_DR_NEXT,
      S_PU_HEAD, S_PU_PREV,
      S_DONE
   } state_type;

   // Count of trailing zeros, zero for a zero argument
   function automatic logic [ORD_W-1:0] low_zeros(input logic [PG_W-1:0] v);
      logic [ORD_W-1:0] n;
      n = '0;
      for (int i = PG_W - 1; i >= 0; i--) begin
         if (v[i]) n = ORD_W'(i);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== src/buddy_page_allocator.sv =====
// Binary buddy page allocator: sequencer around a page metadata and a link memory.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  request | req_valid/ready, cmd, order, page_index,     | in
//          | first_page, end_page                         |
//  result  | rsp_valid/ready, status, block_page,         | out
//          | block_order                                  |
//  csr     | csr_wr_en, csr_wr_data (page_count)          | in
//
// One request at a time. Every step reads the page memories through their registered
// read port and writes back, so cost follows the walk: init grows with page_count and
// the blocks it cuts, alloc with the splits and the pages of the block it marks, free
// with the merges and the pages it marks, reserve with the list nodes visited and the
// pages reserved. Reset empties all lists; the page memories are not cleared and hold
// nothing valid until init. A result waiting on rsp_ready does not stop the next
// request from being taken.
`default_nettype none

module buddy_page_allocator
   import bpa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [ORD_W-1:0]    req_order,
   input  wire logic [PAGE_W-1:0]   req_page_index,
   input  wire logic [PAGE_W-1:0]   req_first_page,
   input  wire logic [PG_W-1:0]     req_end_page,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [PAGE_W-1:0]        rsp_block_page,
   output logic [ORD_W-1:0]         rsp_block_order,
   input  wire logic                csr_wr_en,
   input  wire logic [PG_W-1:0]     csr_wr_data
);

   // Sequencer state
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;     // return point of list drop / push
   state_type sret_ff, sret_in;   // return point of block split

   // Datapath registers
   logic [ORD_W-1:0] j_ff, j_in;
   logic [ORD_W-1:0] k_ff, k_in;
   logic [PG_W-1:0]  p_ff, p_in;
   logic [PG_W-1:0]  b_ff, b_in;
   logic [PG_W-1:0]  t_ff, t_in;
   logic [PG_W-1:0]  rem_ff, rem_in;
   logic [PG_W-1:0]  cur_ff, cur_in;
   logic [PG_W-1:0]  first_ff, first_in;
   logic [PG_W-1:0]  endp_ff, endp_in;
   logic [ORD_W-1:0] lk_ff, lk_in;
   logic [PG_W-1:0]  lp_ff, lp_in;
   logic [PG_W-1:0]  pv_ff, pv_in;
   logic [PG_W-1:0]  nx_ff, nx_in;
   logic [PG_W-1:0]  sp_ff, sp_in;
   logic [ORD_W-1:0] sk_ff, sk_in;
   logic [PG_W-1:0]  sb_ff, sb_in;
   logic             split_ok_ff, split_ok_in;
   status_type       res_status_ff, res_status_in;
   logic [PAGE_W-1:0] res_page_ff, res_page_in;
   logic [ORD_W-1:0] res_order_ff, res_order_in;

   // Result register
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [PAGE_W-1:0] rsp_page_ff;
   logic [ORD_W-1:0] rsp_order_ff;
   logic             rsp_load;

   // Configuration and list heads
   logic [PG_W-1:0]  page_count_ff;
   logic [PG_W-1:0]  head_ff [NUM_ORDERS];

   // Page memories
   meta_type         meta_mem_ff [MAX_PAGES];
   link_type         link_mem_ff [MAX_PAGES];
   meta_type         meta_rd_ff;
   link_type         link_rd_ff;

   // Memory and head controls
   logic [PAGE_W-1:0] rd_addr;
   meta_we_type      meta_we;
   logic [PAGE_W-1:0] meta_wa;
   meta_type         meta_wd;
   link_we_type      link_we;
   logic [PAGE_W-1:0] link_wa;
   link_type         link_wd;
   logic             head_we;
   logic             head_clr;
   logic [ORD_W-1:0] head_wa;
   logic [PG_W-1:0]  head_wd;

   // Shared terms
   logic [PG_W-1:0]  cnt;
   logic [ORD_W-1:0] hidx;
   logic [PG_W-1:0]  head_rd;
   logic [PG_W-1:0]  sz_k;
   logic [PG_W-1:0]  pt_sum;
   logic [PG_W-1:0]  cur_t;
   logic             last_t;
   logic             aligned;
   logic             has_buddy;
   logic [PG_W-1:0]  buddy;
   logic [PG_W-1:0]  blk_end;
   logic [PG_W-1:0]  split_b;
   logic             found;
   logic [ORD_W-1:0] found_i;
   logic             req_take;

   assign cnt      = (page_count_ff > NIL) ? NIL : page_count_ff;
   assign hidx     = (state_ff == S_DR_PREV || state_ff == S_PU_HEAD) ? lk_ff : k_ff;
   assign head_rd  = head_ff[hidx];
   assign sz_k     = PG_W'(1) << k_ff;
   assign pt_sum   = p_ff + t_ff;
   assign cur_t    = cur_ff + t_ff;
   assign last_t   = (t_ff == sz_k - PG_W'(1)) || (pt_sum + PG_W'(1) >= NIL);
   assign aligned  = ((p_ff & ((sz_k << 1) - PG_W'(1))) == '0);
   assign has_buddy = aligned || (p_ff >= sz_k);
   assign buddy    = aligned ? p_ff + sz_k : p_ff - sz_k;
   assign blk_end  = p_ff + sz_k;
   assign split_b  = sp_ff + (PG_W'(1) << (meta_rd_ff.ord - ORD_W'(1)));
   assign req_take = req_valid && req_ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Lowest non-empty list at or above the requested order
   always_comb begin
      found   = 1'b0;
      found_i = '0;
      for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
         if (ORD_W'(i) >= j_ff && head_ff[i] != NIL) begin
            found   = 1'b1;
            found_i = ORD_W'(i);
         end
      end
   end

   // Next state and datapath
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      sret_in       = sret_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      p_in          = p_ff;
      b_in          = b_ff;
      t_in          = t_ff;
      rem_in        = rem_ff;
      cur_in        = cur_ff;
      first_in      = first_ff;
      endp_in       = endp_ff;
      lk_in         = lk_ff;
      lp_in         = lp_ff;
      pv_in         = pv_ff;
      nx_in         = nx_ff;
      sp_in         = sp_ff;
      sk_in         = sk_ff;
      sb_in         = sb_ff;
      split_ok_in   = split_ok_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_order_in  = res_order_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               j_in          = req_order;
               p_in          = {1'b0, req_page_index};
               first_in      = {1'b0, req_first_page};
               endp_in       = req_end_page;
               res_status_in = STS_OK;
               res_page_in   = '0;
               res_order_in  = '0;
               case (cmd_type'(req_cmd))
                  CMD_INIT:  state_in = S_IN_START;
                  CMD_ALLOC: state_in = S_AL_START;
                  CMD_FREE:  state_in = S_FR_START;
                  default:   state_in = S_RS_START;
               endcase
            end
         end
         // Init: cut the segment greedily, highest order first
         S_IN_START: begin
            cur_in   = '0;
            rem_in   = cnt;
            k_in     = ORD_W'(NUM_ORDERS - 1);
            state_in = S_IN_BLK;
         end
         S_IN_BLK: begin
            if (rem_ff >= sz_k) begin
               t_in     = '0;
               state_in = S_IN_PG;
            end else if (k_ff == '0) begin
               state_in = S_DONE;
            end else begin
               k_in = k_ff - ORD_W'(1);
            end
         end
         S_IN_PG: begin
            if (t_ff == sz_k - PG_W'(1)) begin
               lk_in    = k_ff;
               lp_in    = cur_ff;
               ret_in   = S_IN_NEXT;
               state_in = S_PU_HEAD;
            end else begin
               t_in = t_ff + PG_W'(1);
            end
         end
         S_IN_NEXT: begin
            rem_in   = rem_ff - sz_k;
            cur_in   = cur_ff + sz_k;
            state_in = S_IN_BLK;
         end
         // Alloc: split down from the lowest fitting order
         S_AL_START: begin
            if (j_ff >= ORD_W'(NUM_ORDERS) || !found) begin
               res_status_in = STS_NO_BLOCK;
               state_in      = S_DONE;
            end else begin
               k_in     = found_i;
               state_in = S_AL_LOOP;
            end
         end
         S_AL_LOOP: begin
            if (k_ff > j_ff) begin
               sp_in    = head_rd;
               sret_in  = S_AL_SPLIT;
               state_in = S_SP_RD;
            end else begin
               p_in     = head_rd;
               lk_in    = k_ff;
               lp_in    = head_rd;
               t_in     = '0;
               ret_in   = S_AL_MARK;
               state_in = S_DR_RD;
            end
         end
         S_AL_SPLIT: begin
            if (!split_ok_ff) begin
               res_status_in = STS_NO_BLOCK;
               state_in      = S_DONE;
            end else begin
               k_in     = k_ff - ORD_W'(1);
               state_in = S_AL_LOOP;
            end
         end
         S_AL_MARK: begin
            if (last_t) begin
               res_page_in  = p_ff[PAGE_W-1:0];
               res_order_in = j_ff;
               state_in     = S_DONE;
            end else begin
               t_in = t_ff + PG_W'(1);
            end
         end
         // Free: check, then merge with free buddies
         S_FR_START: begin
            if (p_ff >= cnt) begin
               res_status_in = STS_OUT_OF_RANGE;
               state_in      = S_DONE;
            end else begin
               state_in = S_FR_CHECK;
            end
         end
         S_FR_CHECK: begin
            k_in = meta_rd_ff.ord;
            if (meta_rd_ff.ord >= ORD_W'(NUM_ORDERS) ||
                p_ff + (PG_W'(1) << meta_rd_ff.ord) > cnt) begin
               res_status_in = STS_OUT_OF_RANGE;
               state_in      = S_DONE;
            end else if (meta_rd_ff.rsv) begin
               res_status_in = STS_RESERVED;
               state_in      = S_DONE;
            end else if (!meta_rd_ff.alloc) begin
               res_status_in = STS_ALREADY_FREE;
               state_in      = S_DONE;
            end else begin
               state_in = S_FR_MERGE;
            end
         end
         S_FR_MERGE: begin
            if (k_ff + ORD_W'(1) >= ORD_W'(NUM_ORDERS) || !has_buddy || buddy >= cnt) begin
               state_in = S_FR_PUSH;
            end else begin
               b_in     = buddy;
               state_in = S_FR_BUDDY;
            end
         end
         S_FR_BUDDY: begin
            if (meta_rd_ff.ord != k_ff || !meta_rd_ff.head) begin
               state_in = S_FR_PUSH;
            end else begin
               lk_in    = k_ff;
               lp_in    = b_ff;
               ret_in   = S_FR_JOIN;
               state_in = S_DR_RD;
            end
         end
         S_FR_JOIN: begin
            if (b_ff < p_ff) p_in = b_ff;
            k_in     = k_ff + ORD_W'(1);
            state_in = S_FR_ORD;
         end
         S_FR_ORD: begin
            state_in = S_FR_MERGE;
         end
         S_FR_PUSH: begin
            lk_in    = k_ff;
            lp_in    = p_ff;
            t_in     = '0;
            ret_in   = S_FR_MARK;
            state_in = S_PU_HEAD;
         end
         S_FR_MARK: begin
            if (last_t) begin
               res_page_in  = p_ff[PAGE_W-1:0];
               res_order_in = k_ff;
               state_in     = S_DONE;
            end else begin
               t_in = t_ff + PG_W'(1);
            end
         end
         // Reserve: walk every list, highest order first
         S_RS_START: begin
            if (first_ff >= endp_ff) begin
               res_status_in = STS_BAD_RANGE;
               state_in      = S_DONE;
            end else if (endp_ff > cnt) begin
               res_status_in = STS_OUT_OF_RANGE;
               state_in      = S_DONE;
            end else begin
               k_in     = ORD_W'(NUM_ORDERS - 1);
               state_in = S_RS_HEAD;
            end
         end
         S_RS_HEAD: begin
            p_in     = head_rd;
            state_in = S_RS_PAGE;
         end
         S_RS_PAGE: begin
            if (p_ff >= NIL) begin
               if (k_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  k_in     = k_ff - ORD_W'(1);
                  state_in = S_RS_HEAD;
               end
            end else if (p_ff >= first_ff && blk_end <= endp_ff) begin
               lk_in    = k_ff;
               lp_in    = p_ff;
               t_in     = '0;
               ret_in   = S_RS_FILL;
               state_in = S_DR_RD;
            end else if ((p_ff < first_ff && blk_end > first_ff) ||
                         (p_ff < endp_ff && blk_end > endp_ff)) begin
               sp_in    = p_ff;
               sret_in  = S_RS_SPLIT;
               state_in = S_SP_RD;
            end else begin
               state_in = S_RS_RD;
            end
         end
         S_RS_RD: begin
            state_in = S_RS_NEXT;
         end
         S_RS_NEXT: begin
            p_in     = link_rd_ff.nxt;
            state_in = S_RS_PAGE;
         end
         S_RS_FILL: begin
            if (last_t) state_in = S_RS_HEAD;
            else        t_in     = t_ff + PG_W'(1);
         end
         S_RS_SPLIT: begin
            state_in = split_ok_ff ? S_RS_HEAD : S_RS_RD;
         end
         // Split of the block at sp
         S_SP_RD: begin
            state_in = S_SP_CHK;
         end
         S_SP_CHK: begin
            if (meta_rd_ff.ord == '0 || meta_rd_ff.ord >= ORD_W'(NUM_ORDERS) ||
                split_b >= NIL) begin
               split_ok_in = 1'b0;
               state_in    = sret_ff;
            end else begin
               sk_in    = meta_rd_ff.ord;
               sb_in    = split_b;
               lk_in    = meta_rd_ff.ord;
               lp_in    = sp_ff;
               ret_in   = S_SP_ORD;
               state_in = S_DR_RD;
            end
         end
         S_SP_ORD: begin
            state_in = S_SP_BUD;
         end
         S_SP_BUD: begin
            lk_in    = sk_ff - ORD_W'(1);
            lp_in    = sp_ff;
            ret_in   = S_SP_PUSHB;
            state_in = S_PU_HEAD;
         end
         S_SP_PUSHB: begin
            lk_in    = sk_ff - ORD_W'(1);
            lp_in    = sb_ff;
            ret_in   = S_SP_END;
            state_in = S_PU_HEAD;
         end
         S_SP_END: begin
            split_ok_in = 1'b1;
            state_in    = sret_ff;
         end
         // List drop of page lp from list lk
         S_DR_RD: begin
            state_in = S_DR_PREV;
         end
         S_DR_PREV: begin
            pv_in    = link_rd_ff.prv;
            nx_in    = link_rd_ff.nxt;
            state_in = S_DR_NEXT;
         end
         S_DR_NEXT: begin
            state_in = ret_ff;
         end
         // List push of page lp onto list lk
         S_PU_HEAD: begin
            nx_in    = head_rd;
            state_in = (head_rd < NIL) ? S_PU_PREV : ret_ff;
         end
         S_PU_PREV: begin
            state_in = ret_ff;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory, list head and handshake controls
   always_comb begin
      req_ready = 1'b0;
      rd_addr   = p_ff[PAGE_W-1:0];
      meta_we   = '0;
      meta_wa   = p_ff[PAGE_W-1:0];
      meta_wd   = '0;
      link_we   = '0;
      link_wa   = lp_ff[PAGE_W-1:0];
      link_wd   = '0;
      head_we   = 1'b0;
      head_clr  = 1'b0;
      head_wa   = lk_ff;
      head_wd   = lp_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_IN_START: begin
            head_clr = 1'b1;
         end
         S_IN_PG: begin
            meta_wa       = cur_t[PAGE_W-1:0];
            meta_we       = '1;
            meta_wd.ord   = (t_ff == '0) ? k_ff : low_zeros(t_ff);
            meta_wd.head  = (t_ff == '0);
         end
         S_AL_MARK: begin
            meta_wa       = pt_sum[PAGE_W-1:0];
            meta_we.alloc = 1'b1;
            meta_we.head  = (t_ff == '0);
            meta_wd.alloc = 1'b1;
         end
         S_FR_START: begin
            rd_addr = p_ff[PAGE_W-1:0];
         end
         S_FR_MERGE: begin
            rd_addr = buddy[PAGE_W-1:0];
         end
         S_FR_JOIN: begin
            meta_wa      = b_ff[PAGE_W-1:0];
            meta_we.head = 1'b1;
         end
         S_FR_ORD: begin
            meta_wa     = p_ff[PAGE_W-1:0];
            meta_we.ord = 1'b1;
            meta_wd.ord = k_ff;
         end
         S_FR_MARK: begin
            meta_wa       = pt_sum[PAGE_W-1:0];
            meta_we.alloc = 1'b1;
            meta_we.head  = (t_ff == '0);
            meta_wd.head  = 1'b1;
         end
         S_RS_RD: begin
            rd_addr = p_ff[PAGE_W-1:0];
         end
         S_RS_FILL: begin
            meta_wa       = pt_sum[PAGE_W-1:0];
            meta_we.head  = 1'b1;
            meta_we.alloc = 1'b1;
            meta_we.rsv   = 1'b1;
            meta_wd.rsv   = 1'b1;
         end
         S_SP_RD: begin
            rd_addr = sp_ff[PAGE_W-1:0];
         end
         S_SP_ORD: begin
            meta_wa     = sp_ff[PAGE_W-1:0];
            meta_we.ord = 1'b1;
            meta_wd.ord = sk_ff - ORD_W'(1);
         end
         S_SP_BUD: begin
            meta_wa      = sb_ff[PAGE_W-1:0];
            meta_we.ord  = 1'b1;
            meta_we.head = 1'b1;
            meta_wd.ord  = sk_ff - ORD_W'(1);
            meta_wd.head = 1'b1;
         end
         S_DR_RD: begin
            rd_addr = lp_ff[PAGE_W-1:0];
         end
         S_DR_PREV: begin
            if (link_rd_ff.prv < NIL) begin
               link_wa     = link_rd_ff.prv[PAGE_W-1:0];
               link_we.nxt = 1'b1;
               link_wd.nxt = link_rd_ff.nxt;
            end else begin
               head_we = 1'b1;
               head_wd = link_rd_ff.nxt;
            end
         end
         S_DR_NEXT: begin
            if (nx_ff < NIL) begin
               link_wa     = nx_ff[PAGE_W-1:0];
               link_we.prv = 1'b1;
               link_wd.prv = pv_ff;
            end
         end
         S_PU_HEAD: begin
            link_wa     = lp_ff[PAGE_W-1:0];
            link_we     = '1;
            link_wd.nxt = head_rd;
            link_wd.prv = NIL;
            head_we     = 1'b1;
            head_wd     = lp_ff;
         end
         S_PU_PREV: begin
            link_wa     = nx_ff[PAGE_W-1:0];
            link_we.prv = 1'b1;
            link_wd.prv = lp_ff;
         end
         default: begin
         end
      endcase
   end

   // Page memories: bit-enable writes, registered reads
   always_ff @(posedge clock) begin
      if (meta_we.ord)   meta_mem_ff[meta_wa].ord   <= meta_wd.ord;
      if (meta_we.rsv)   meta_mem_ff[meta_wa].rsv   <= meta_wd.rsv;
      if (meta_we.alloc) meta_mem_ff[meta_wa].alloc <= meta_wd.alloc;
      if (meta_we.head)  meta_mem_ff[meta_wa].head  <= meta_wd.head;
      if (link_we.nxt)   link_mem_ff[link_wa].nxt   <= link_wd.nxt;
      if (link_we.prv)   link_mem_ff[link_wa].prv   <= link_wd.prv;
      meta_rd_ff <= meta_mem_ff[rd_addr];
      link_rd_ff <= link_mem_ff[rd_addr];
   end

   // List heads
   always_ff @(posedge clock) begin
      if (reset || head_clr) begin
         for (int i = 0; i < NUM_ORDERS; i++) head_ff[i] <= NIL;
      end else if (head_we) begin
         head_ff[head_wa] <= head_wd;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         page_count_ff <= PG_W'(MAX_PAGES);
      end else begin
         state_ff <= state_in;
         if (rsp_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_wr_en) page_count_ff <= csr_wr_data;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      sret_ff       <= sret_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      p_ff          <= p_in;
      b_ff          <= b_in;
      t_ff          <= t_in;
      rem_ff        <= rem_in;
      cur_ff        <= cur_in;
      first_ff      <= first_in;
      endp_ff       <= endp_in;
      lk_ff         <= lk_in;
      lp_ff         <= lp_in;
      pv_ff         <= pv_in;
      nx_ff         <= nx_in;
      sp_ff         <= sp_in;
      sk_ff         <= sk_in;
      sb_ff         <= sb_in;
      split_ok_ff   <= split_ok_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_order_ff  <= res_order_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_page_ff   <= res_page_ff;
         rsp_order_ff  <= res_order_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_page  = rsp_page_ff;
   assign rsp_block_order = rsp_order_ff;

endmodule

`default_nettype wire

// ===== src/bpa_checker.sv =====
// Port-level checks for the buddy page allocator, bound to the top level.
`default_nettype none

module bpa_checker
   import bpa_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [1:0]          req_cmd,
   input wire logic [ORD_W-1:0]    req_order,
   input wire logic [PAGE_W-1:0]   req_page_index,
   input wire logic [PAGE_W-1:0]   req_first_page,
   input wire logic [PG_W-1:0]     req_end_page,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [2:0]          rsp_status,
   input wire logic [PAGE_W-1:0]   rsp_block_page,
   input wire logic [ORD_W-1:0]    rsp_block_order,
   input wire logic                csr_wr_en,
   input wire logic [PG_W-1:0]     csr_wr_data
);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_status) && $stable(rsp_block_page) && $stable(rsp_block_order))
      else $error("result payload changed while stalled");

   // Error results carry no block
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_block_page == '0 && rsp_block_order == '0)
      else $error("error result with nonzero block");

   // Every request leaves the sequencer busy in the cycle after it is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire
